FILE: src/dast_pkg.sv
package dast_pkg;

    // Address width follows from six address bytes.
    localparam int ADDR_BYTES = 6;
    localparam int ADDR_W     = 8 * ADDR_BYTES;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;
    localparam int OUT_DATA_W = 16;

    // Request kinds; the unused code behaves as a find.
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FOUND   = 3'd0,
        STATUS_ABSENT  = 3'd1,
        STATUS_ADDED   = 3'd2,
        STATUS_ALREADY = 3'd3,
        STATUS_FULL    = 3'd4,
        STATUS_REMOVED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } state_t;

    // Packed so that status lands in the lowest bits of the output beat.
    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic               present;
        status_t            status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

FILE: src/device_address_set_table.sv
// Device address set table: a set of 48-bit device addresses, no duplicates.
//
// Slave channel: one request per beat. s_tuser carries the kind (find, add,
// remove; the unused code acts as a find), s_tdata the device address.
// Master channel: one result beat per request with status, whether the
// address was held beforehand, and the number of valid entries afterwards.
//
// Each request walks all TABLE_DEPTH entries through one compare unit fed
// by the address RAM, one entry a cycle, each compared in the cycle after
// its registered read; it then writes back in UPDATE and hands the result
// over from DONE. No new request is taken until the last one has left DONE;
// s_tready is high only while the sequencer is idle.
//
// Reset clears all valid marks and the entry count at once; no clearing
// pass is needed, and addresses of never-written entries are never seen.
// A result beat sits in the output register until m_tready takes it; the
// next request is accepted meanwhile and holds in its final stage if the
// output register is still occupied when it finishes.
module device_address_set_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // device_addr[47:0]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[2:0], present[3], entry_count[8:4], zero[15:9]
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [dast_pkg::ADDR_W-1:0] ram_wdata;
    logic [IDX_W-1:0]            ram_raddr;
    logic [dast_pkg::ADDR_W-1:0] ram_rdata;

    logic                        res_valid;
    logic                        res_ready;
    dast_pkg::result_t           res_data;

    logic                        out_valid_reg, out_valid_next;
    dast_pkg::result_t           out_data_reg, out_data_next;

    dast_ram #(
        .WIDTH (dast_pkg::ADDR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dast_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_addr   (s_tdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // Take a new result whenever the output register is empty or draining.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_data_next = res_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(dast_pkg::OUT_DATA_W - dast_pkg::RESULT_W){1'b0}}, out_data_reg};

endmodule

FILE: src/dast_ram.sv
module dast_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/dast_core.sv
module dast_core #(
    parameter int TABLE_DEPTH = 16,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request side
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dast_pkg::KIND_W-1:0]   in_kind,
    input  logic [dast_pkg::ADDR_W-1:0]   in_addr,
    // address store
    output logic                          ram_we,
    output logic [IDX_W-1:0]              ram_waddr,
    output logic [dast_pkg::ADDR_W-1:0]   ram_wdata,
    output logic [IDX_W-1:0]              ram_raddr,
    input  logic [dast_pkg::ADDR_W-1:0]   ram_rdata,
    // result side
    output logic                          res_valid,
    input  logic                          res_ready,
    output dast_pkg::result_t             res_data
);

    dast_pkg::state_t            state_reg, state_next;
    logic [dast_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [dast_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0]            issue_reg, issue_next;
    logic                        cmp_v_reg, cmp_v_next;
    logic [IDX_W-1:0]            cmp_idx_reg, cmp_idx_next;
    logic                        hit_reg, hit_next;
    logic [IDX_W-1:0]            hit_idx_reg, hit_idx_next;
    logic                        free_reg, free_next;
    logic [IDX_W-1:0]            free_idx_reg, free_idx_next;
    logic [TABLE_DEPTH-1:0]      valid_reg, valid_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    dast_pkg::result_t           result_reg, result_next;

    logic                        issue_more;
    logic                        last_cmp;
    logic                        match;
    logic                        do_add;
    logic                        do_remove;
    logic [CNT_W+dast_pkg::COUNT_W-1:0] count_ext;

    assign issue_more = (issue_reg < CNT_W'(TABLE_DEPTH));
    assign last_cmp   = cmp_v_reg && (cmp_idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign match      = cmp_v_reg && valid_reg[cmp_idx_reg] && (ram_rdata == addr_reg);
    assign do_add     = (kind_reg == dast_pkg::KIND_ADD) && !hit_reg && free_reg;
    assign do_remove  = (kind_reg == dast_pkg::KIND_REMOVE) && hit_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dast_pkg::ST_IDLE:   if (in_valid)  state_next = dast_pkg::ST_SCAN;
            dast_pkg::ST_SCAN:   if (last_cmp)  state_next = dast_pkg::ST_UPDATE;
            dast_pkg::ST_UPDATE: state_next = dast_pkg::ST_DONE;
            dast_pkg::ST_DONE:   if (res_ready) state_next = dast_pkg::ST_IDLE;
            default:             state_next = dast_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = (state_reg == dast_pkg::ST_IDLE);
        res_valid = (state_reg == dast_pkg::ST_DONE);
        res_data  = result_reg;
        ram_raddr = issue_reg[IDX_W-1:0];
        ram_we    = (state_reg == dast_pkg::ST_UPDATE) && do_add;
        ram_waddr = free_idx_reg;
        ram_wdata = addr_reg;
    end

    // datapath
    always_comb
    begin
        kind_next     = kind_reg;
        addr_next     = addr_reg;
        issue_next    = issue_reg;
        cmp_v_next    = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        valid_next    = valid_reg;
        count_next    = count_reg;
        result_next   = result_reg;
        count_ext     = {{dast_pkg::COUNT_W{1'b0}}, count_reg};

        unique case (state_reg)
            dast_pkg::ST_IDLE:
            begin
                kind_next  = in_kind;
                addr_next  = in_addr;
                issue_next = '0;
                hit_next   = 1'b0;
                free_next  = 1'b0;
            end
            dast_pkg::ST_SCAN:
            begin
                // issue one read a cycle, compare the entry read the cycle before
                if (issue_more)
                begin
                    issue_next   = issue_reg + CNT_W'(1);
                    cmp_v_next   = 1'b1;
                    cmp_idx_next = issue_reg[IDX_W-1:0];
                end
                if (match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                end
                if (cmp_v_reg && !valid_reg[cmp_idx_reg] && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = cmp_idx_reg;
                end
            end
            dast_pkg::ST_UPDATE:
            begin
                if (do_add)
                begin
                    valid_next[free_idx_reg] = 1'b1;
                    count_next               = count_reg + CNT_W'(1);
                end
                else if (do_remove)
                begin
                    valid_next[hit_idx_reg] = 1'b0;
                    count_next              = count_reg - CNT_W'(1);
                end
                count_ext           = {{dast_pkg::COUNT_W{1'b0}}, count_next};
                result_next.present = hit_reg;
                result_next.entry_count = count_ext[dast_pkg::COUNT_W-1:0];
                priority if (kind_reg == dast_pkg::KIND_ADD)
                begin
                    if (hit_reg)       result_next.status = dast_pkg::STATUS_ALREADY;
                    else if (free_reg) result_next.status = dast_pkg::STATUS_ADDED;
                    else               result_next.status = dast_pkg::STATUS_FULL;
                end
                else if (kind_reg == dast_pkg::KIND_REMOVE)
                begin
                    result_next.status = hit_reg ? dast_pkg::STATUS_REMOVED
                                                 : dast_pkg::STATUS_ABSENT;
                end
                else
                begin
                    result_next.status = hit_reg ? dast_pkg::STATUS_FOUND
                                                 : dast_pkg::STATUS_ABSENT;
                end
            end
            dast_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dast_pkg::ST_IDLE;
            cmp_v_reg <= 1'b0;
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmp_v_reg <= cmp_v_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        addr_reg     <= addr_next;
        issue_reg    <= issue_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        result_reg   <= result_next;
    end

endmodule

FILE: src/dast_checker.sv
module dast_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic [2:0] st;
    assign st = m_tdata[2:0];

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // One request at a time: drop ready right after an accepted beat.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after an accepted request");

    // Only defined status codes leave the block, padding stays zero.
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (st <= dast_pkg::STATUS_REMOVED) && (m_tdata[15:9] == 7'd0))
        else $error("illegal status code or nonzero padding");

    // Present flag agrees with the status.
    a_present_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3] == ((st == dast_pkg::STATUS_FOUND)
                                 || (st == dast_pkg::STATUS_ALREADY)
                                 || (st == dast_pkg::STATUS_REMOVED)))
        else $error("present flag disagrees with status");

endmodule

bind device_address_set_table dast_checker u_dast_checker (.*);

FILE: tb/tb_device_address_set_table.sv
module tb_device_address_set_table;

    timeunit 1ns;
    timeprecision 1ps;

    import dast_pkg::*;

    localparam int DEPTH      = 16;
    localparam int POOL_SIZE  = 24;
    localparam int PHASE_LEN  = 270;
    localparam int IDLE_LIMIT = 3000;   // cycles without any beat before giving up

    // The unused kind code; the block treats it as a find.
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [ADDR_W-1:0] s_tdata;      // device_addr[47:0]
    logic [KIND_W-1:0] s_tuser;      // kind[1:0]
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;      // status[2:0], present[3], entry_count[8:4], zero[15:9]

    device_address_set_table #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // One row of the directed sequence. Where typed is set, want holds the
    // result read straight off the table contents; otherwise the shadow
    // table supplies it.
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        result_t           want;
    } dir_row_t;

    // Shadow copy of the address table.
    logic [ADDR_W-1:0] shadow_addr [DEPTH];
    bit                shadow_valid [DEPTH];
    int                shadow_count;

    result_t           awaited_results [$];
    dir_row_t          dir_rows [$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    int err_count;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    // Clock: 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the shadow table and return the result it gives.
    function automatic result_t table_apply(logic [KIND_W-1:0] kind,
                                            logic [ADDR_W-1:0] addr);
        int      hit = -1;
        int      slot = -1;
        result_t r;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit < 0 && shadow_valid[i] && shadow_addr[i] == addr)
                hit = i;
            if (slot < 0 && !shadow_valid[i])
                slot = i;
        end
        r.present = (hit >= 0);
        case (kind)
            KIND_ADD:
            begin
                if (hit >= 0)
                    r.status = STATUS_ALREADY;
                else if (slot < 0)
                    r.status = STATUS_FULL;
                else
                begin
                    shadow_addr[slot]  = addr;
                    shadow_valid[slot] = 1'b1;
                    shadow_count++;
                    r.status = STATUS_ADDED;
                end
            end
            KIND_REMOVE:
            begin
                if (hit >= 0)
                begin
                    shadow_valid[hit] = 1'b0;
                    shadow_count--;
                    r.status = STATUS_REMOVED;
                end
                else
                    r.status = STATUS_ABSENT;
            end
            default:
                // find, and the spare code acting as a find
                r.status = (hit >= 0) ? STATUS_FOUND : STATUS_ABSENT;
        endcase
        r.entry_count = shadow_count[COUNT_W-1:0];
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[ADDR_W-1:0];
    endfunction

    task automatic add_row(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr, bit typed,
                           status_t st, bit pres, int cnt);
        dir_row_t row;
        row.kind             = kind;
        row.addr             = addr;
        row.typed            = typed;
        row.want.status      = st;
        row.want.present     = pres;
        row.want.entry_count = cnt[COUNT_W-1:0];
        dir_rows.push_back(row);
    endtask

    // Offer one request beat. Call at a falling edge; returns at the falling
    // edge after the beat was taken. Random sender gaps go in front.
    task automatic offer_request(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                 bit typed, result_t want);
        result_t model;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= addr;
        do
            @(posedge clk);
        while (!s_tready);
        // Beat taken: advance the shadow table and queue what must come back.
        model = table_apply(kind, addr);
        awaited_results.push_back(typed ? want : model);
        @(negedge clk);
    endtask

    // Receiver: hold m_tready low through a requested hold-off, else stall
    // at the current rate. Changes land on the falling edge.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker: compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        result_t want;
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, got status %0d present %0d count %0d",
                         $time, got.status, got.present, got.entry_count);
                err_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.status !== want.status || got.present !== want.present ||
                    got.entry_count !== want.entry_count ||
                    m_tdata[OUT_DATA_W-1:RESULT_W] !== '0)
                begin
                    $display("%0t: result mismatch, expected status %0d present %0d count %0d",
                             $time, want.status, want.present, want.entry_count);
                    $display("%0t:                  got status %0d present %0d count %0d pad %0h",
                             $time, got.status, got.present, got.entry_count,
                             m_tdata[OUT_DATA_W-1:RESULT_W]);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: give up when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("[device_address_set_table] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        result_t           none;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        int                pick;
        bit                filling;

        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = KIND_FIND;
        err_count      = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        shadow_count   = 0;
        none           = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_addr[i]  = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = rand_addr();

        // Directed sequence: empty table, address extremes, duplicate add,
        // the spare kind, remove of an absent address, then fill to full and
        // probe add-when-full, duplicate-when-full and reuse of a freed entry.
        add_row(KIND_FIND,   48'h0000_0000_0000, 1, STATUS_ABSENT,  0, 0);
        add_row(KIND_REMOVE, 48'hFFFF_FFFF_FFFF, 1, STATUS_ABSENT,  0, 0);
        add_row(KIND_ADD,    48'h0000_0000_0000, 1, STATUS_ADDED,   0, 1);
        add_row(KIND_ADD,    48'hFFFF_FFFF_FFFF, 1, STATUS_ADDED,   0, 2);
        add_row(KIND_ADD,    48'hFFFF_FFFF_FFFF, 1, STATUS_ALREADY, 1, 2);
        add_row(KIND_SPARE,  48'hFFFF_FFFF_FFFF, 1, STATUS_FOUND,   1, 2);
        add_row(KIND_FIND,   48'h0000_0000_0000, 1, STATUS_FOUND,   1, 2);
        add_row(KIND_REMOVE, 48'h0000_0000_0000, 1, STATUS_REMOVED, 1, 1);
        add_row(KIND_ADD,    48'h5555_5555_5555, 1, STATUS_ADDED,   0, 2);
        add_row(KIND_ADD,    48'hAAAA_AAAA_AAAA, 1, STATUS_ADDED,   0, 3);
        for (int i = 0; i < DEPTH - 3; i++)
            add_row(KIND_ADD, 48'h0123_4567_8900 + i, 0, STATUS_FOUND, 0, 0);
        add_row(KIND_ADD,    48'hDEAD_BEEF_0000, 1, STATUS_FULL,    0, 16);
        add_row(KIND_ADD,    48'hFFFF_FFFF_FFFF, 1, STATUS_ALREADY, 1, 16);
        add_row(KIND_REMOVE, 48'hFFFF_FFFF_FFFF, 1, STATUS_REMOVED, 1, 15);
        add_row(KIND_ADD,    48'hDEAD_BEEF_0000, 1, STATUS_ADDED,   0, 16);

        // Hold reset, then release it on a falling edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            offer_request(dir_rows[i].kind, dir_rows[i].addr, dir_rows[i].typed,
                          dir_rows[i].want);

        // Random traffic in idling phases: none, sender idle, receiver
        // stalling, both, then none again. The kind mix swings between
        // filling and draining so the table passes through empty and full.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
                3:       begin send_idle_pct = 18; recv_stall_pct = 18; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                // Long receiver hold-off while beats keep coming: back up
                // the output register and stall the input.
                if (phase == 0 && n == 100)
                    hold_cycles = 120;
                // Drain completely before going on.
                if (phase == 2 && n == 135)
                begin
                    s_tvalid <= 1'b0;
                    while (awaited_results.size() != 0)
                        @(negedge clk);
                end
                filling = ((n / 40) % 2) == 0;
                pick    = $urandom_range(99);
                if (filling)
                    kind = (pick < 55) ? KIND_ADD : (pick < 75) ? KIND_REMOVE :
                           (pick < 95) ? KIND_FIND : KIND_SPARE;
                else
                    kind = (pick < 20) ? KIND_ADD : (pick < 65) ? KIND_REMOVE :
                           (pick < 95) ? KIND_FIND : KIND_SPARE;
                if ($urandom_range(99) < 85)
                    addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
                else
                    addr = rand_addr();
                offer_request(kind, addr, 1'b0, none);
            end
        end

        // Drop valid, wait for the last results, then let things settle.
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (2 * (DEPTH + 4)) @(posedge clk);

        if (awaited_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, awaited_results.size());
            err_count++;
        end
        if (err_count == 0)
            $display("[device_address_set_table] OK");
        else
            $display("[device_address_set_table] ERROR");
        $finish;
    end

endmodule
